FILE: hw/rtl/gcw_pkg.sv
// ----------------------------------------------------------------------------
// gcw_pkg: shared types and constants of the grid wall classifier
// Cell kind codes, configuration register indexes, count widths and the
// neighbour offset tables walked by the classify sequencer.
// ----------------------------------------------------------------------------
package gcw_pkg;

    localparam int KIND_W  = 2;
    localparam int COUNT_W = 5;
    localparam int STEP_W  = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_FREE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OBSTACLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WALL     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_CUTOFF = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NBR_MODE    = 2'd3;

    localparam logic [COUNT_W-1:0] CUTOFF_RESET = 5'd4;
    localparam int MAX_SIDE_DEFAULT = 64;

    localparam int CROSS_STEPS = 8;
    localparam int BOX_STEPS   = 24;
    localparam int CROSS_IDX_W = $clog2(CROSS_STEPS);

    typedef struct packed {
        logic signed [2:0] dc;
        logic signed [2:0] dr;
    } t_offset;

    // Cross: four arms, inner cell then outer cell of each arm.
    localparam logic signed [2:0] CROSS_DC [CROSS_STEPS] = '{
        3'sd1, 3'sd2, 3'sd0, 3'sd0, -3'sd1, -3'sd2, 3'sd0, 3'sd0
    };
    localparam logic signed [2:0] CROSS_DR [CROSS_STEPS] = '{
        3'sd0, 3'sd0, -3'sd1, -3'sd2, 3'sd0, 3'sd0, 3'sd1, 3'sd2
    };

    // Box: 5x5 around the centre, centre left out.
    localparam logic signed [2:0] BOX_DC [BOX_STEPS] = '{
        -3'sd2, -3'sd2, -3'sd2, -3'sd2, -3'sd2,
        -3'sd1, -3'sd1, -3'sd1, -3'sd1, -3'sd1,
        3'sd0, 3'sd0, 3'sd0, 3'sd0,
        3'sd1, 3'sd1, 3'sd1, 3'sd1, 3'sd1,
        3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd2
    };
    localparam logic signed [2:0] BOX_DR [BOX_STEPS] = '{
        -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2,
        -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2,
        -3'sd2, -3'sd1, 3'sd1, 3'sd2,
        -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2,
        -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2
    };

    function automatic t_offset gcw_step_offset(input logic mode,
                                                input logic [STEP_W-1:0] step);
        t_offset o;
        if (mode) begin
            o.dc = BOX_DC[step];
            o.dr = BOX_DR[step];
        end else begin
            o.dc = CROSS_DC[step[CROSS_IDX_W-1:0]];
            o.dr = CROSS_DR[step[CROSS_IDX_W-1:0]];
        end
        return o;
    endfunction

endpackage

FILE: hw/rtl/grid_wall_classifier_top.sv
// ----------------------------------------------------------------------------
// grid_wall_classifier_top: occupancy grid with neighbour-count wall marking
// Holds a grid of cell kinds, writes cells on request and classifies
// obstacle cells into walls from their occupied neighbours.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with o_done high, and the receiver cannot hold
// it off. A write or an out-of-grid request passes through S_CENTER alone
// before o_done; classifying a free or wall cell also passes S_CWAIT.
// Classifying an obstacle walks its neighbours through one shared coordinate
// unit and the single read port of the cell store, one neighbour per cycle,
// 8 neighbours in cross mode and 24 in box mode; the centre lookup comes
// before the scan, the last read return and the write-back after it.
// busy stays high until the cycle of o_done, in which a new request may
// already be taken. The cell store has no reset: every cell of the grid in
// use must be written before it is classified or used as a neighbour.
// Configuration writes are always ready and must only come while idle.
// ----------------------------------------------------------------------------
module grid_wall_classifier_top #(
    parameter int MAX_SIDE = gcw_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // request channel
    input  logic                                      start,
    output logic                                      busy,
    input  logic                                      i_command,
    input  logic [$clog2(MAX_SIDE)-1:0]               i_col,
    input  logic [$clog2(MAX_SIDE)-1:0]               i_row,
    input  logic [gcw_pkg::KIND_W-1:0]                i_kind_in,
    // result
    output logic                                      o_done,
    output logic [gcw_pkg::KIND_W-1:0]                o_kind_out,
    output logic [gcw_pkg::COUNT_W-1:0]               o_neighbour_count,
    output logic                                      o_became_wall,
    output logic                                      o_out_of_range,
    // configuration write channel
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [gcw_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [(($clog2(MAX_SIDE+1) > gcw_pkg::COUNT_W) ?
                   $clog2(MAX_SIDE+1) : gcw_pkg::COUNT_W)-1:0] i_cfg_data
);
    import gcw_pkg::*;

    localparam int COORD_W = $clog2(MAX_SIDE);
    localparam int SIZE_W  = $clog2(MAX_SIDE+1);
    localparam int ADDR_W  = $clog2(MAX_SIDE*MAX_SIDE);
    localparam int DEPTH   = MAX_SIDE*MAX_SIDE;
    localparam logic [SIZE_W-1:0] SIDE_S = SIZE_W'(MAX_SIDE);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CENTER = 3'd1;  // range check, write or centre read
    localparam logic [2:0] S_CWAIT  = 3'd2;  // centre kind returns
    localparam logic [2:0] S_SCAN   = 3'd3;  // one neighbour read per cycle
    localparam logic [2:0] S_DRAIN  = 3'd4;  // last neighbour returns
    localparam logic [2:0] S_DONE   = 3'd5;  // cutoff compare, write-back

    // configuration
    logic [SIZE_W-1:0]  r_grid_w;
    logic [SIZE_W-1:0]  r_grid_h;
    logic [COUNT_W-1:0] r_cutoff;
    logic               r_mode;
    logic [SIZE_W-1:0]  eff_w;
    logic [SIZE_W-1:0]  eff_h;

    // sequencer
    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic                r_cmd;
    logic [COORD_W-1:0]  r_col;
    logic [COORD_W-1:0]  r_row;
    logic [KIND_W-1:0]   r_kind_in;
    logic [ADDR_W-1:0]   r_caddr;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   last_step;
    logic [COUNT_W-1:0]  r_count;
    logic                r_pend_valid;
    logic                r_pend_in;
    logic                r_pend_outer;
    logic                r_arm_ok;
    logic                occ;
    logic                add_one;

    // result registers
    logic                r_done;
    logic [KIND_W-1:0]   r_kind_o;
    logic [COUNT_W-1:0]  r_cnt_o;
    logic                r_bw_o;
    logic                r_oor_o;

    // shared unit and store
    t_offset             offset;
    logic [ADDR_W-1:0]   unit_addr;
    logic                unit_inside;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [KIND_W-1:0]   ram_wdata;
    logic [KIND_W-1:0]   ram_rdata;
    logic [KIND_W-1:0]   wr_kind;
    logic                pass;
    logic                accept;

    assign accept = start && !busy;
    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // sizes above the store's side saturate
    assign eff_w = (r_grid_w > SIDE_S) ? SIDE_S : r_grid_w;
    assign eff_h = (r_grid_h > SIDE_S) ? SIDE_S : r_grid_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= SIDE_S;
            r_grid_h <= SIDE_S;
            r_cutoff <= CUTOFF_RESET;
            r_mode   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_w <= i_cfg_data[SIZE_W-1:0];
                CFG_GRID_HEIGHT: r_grid_h <= i_cfg_data[SIZE_W-1:0];
                CFG_WALL_CUTOFF: r_cutoff <= i_cfg_data[COUNT_W-1:0];
                CFG_NBR_MODE:    r_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // centre uses offset zero, the scan walks the offset table
    always_comb begin
        if (r_state == S_SCAN) begin
            offset = gcw_step_offset(r_mode, r_step);
        end else begin
            offset = '0;
        end
    end

    gcw_nbr_unit #(
        .MAX_SIDE (MAX_SIDE)
    ) u_nbr (
        .i_col        (r_col),
        .i_row        (r_row),
        .i_offset     (offset),
        .i_eff_width  (eff_w),
        .i_eff_height (eff_h),
        .o_addr       (unit_addr),
        .o_inside     (unit_inside)
    );

    assign wr_kind = (r_kind_in > KIND_WALL) ? KIND_FREE : r_kind_in;
    assign pass    = (r_count >= r_cutoff);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = unit_addr;
        ram_wdata = wr_kind;
        if (r_state == S_CENTER && unit_inside && !r_cmd) begin
            ram_we = 1'b1;
        end else if (r_state == S_DONE && pass) begin
            ram_we    = 1'b1;
            ram_waddr = r_caddr;
            ram_wdata = KIND_WALL;
        end
    end

    gcw_ram #(
        .WIDTH (KIND_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (unit_addr),
        .o_rdata (ram_rdata)
    );

    assign last_step = r_mode ? STEP_W'(BOX_STEPS - 1) : STEP_W'(CROSS_STEPS - 1);

    // a returned neighbour counts when in the grid and occupied; in cross
    // mode the outer cell of an arm also needs its inner cell counted
    assign occ = r_pend_in && (ram_rdata == KIND_OBSTACLE || ram_rdata == KIND_WALL);
    assign add_one = r_pend_valid && (r_mode ? occ : (r_pend_outer ? (occ && r_arm_ok) : occ));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (accept) n_state = S_CENTER;
            S_CENTER: n_state = (unit_inside && r_cmd) ? S_CWAIT : S_IDLE;
            S_CWAIT:  n_state = (ram_rdata == KIND_OBSTACLE) ? S_SCAN : S_IDLE;
            S_SCAN:   if (r_step == last_step) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_done       <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_done       <= 1'b0;
            r_pend_valid <= (r_state == S_SCAN);
            case (r_state)
                S_CENTER: begin
                    if (!unit_inside || !r_cmd) begin
                        r_done <= 1'b1;
                    end
                end
                S_CWAIT: begin
                    if (ram_rdata != KIND_OBSTACLE) begin
                        r_done <= 1'b1;
                    end
                end
                S_DONE: begin
                    r_done <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_command;
            r_col     <= i_col;
            r_row     <= i_row;
            r_kind_in <= i_kind_in;
        end
        r_pend_in    <= unit_inside;
        r_pend_outer <= r_step[0];
        if (r_pend_valid && !r_mode && !r_pend_outer) begin
            r_arm_ok <= occ;
        end
        case (r_state)
            S_CENTER: begin
                r_caddr <= unit_addr;
                r_cnt_o <= '0;
                r_bw_o  <= 1'b0;
                r_oor_o <= !unit_inside;
                r_kind_o <= unit_inside ? wr_kind : KIND_FREE;
            end
            S_CWAIT: begin
                r_kind_o <= ram_rdata;
                r_step   <= '0;
                r_count  <= '0;
                r_arm_ok <= 1'b0;
            end
            S_SCAN: begin
                r_step <= r_step + 1'b1;
                if (add_one) r_count <= r_count + 1'b1;
            end
            S_DRAIN: begin
                if (add_one) r_count <= r_count + 1'b1;
            end
            S_DONE: begin
                r_cnt_o  <= r_count;
                r_bw_o   <= pass;
                r_kind_o <= pass ? KIND_WALL : KIND_OBSTACLE;
            end
            default: begin
            end
        endcase
    end

    assign o_done            = r_done;
    assign o_kind_out        = r_kind_o;
    assign o_neighbour_count = r_cnt_o;
    assign o_became_wall     = r_bw_o;
    assign o_out_of_range    = r_oor_o;

`ifndef SYNTHESIS
    // a result only follows a request in flight
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a request in flight");

    // an accepted request occupies the sequencer
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted request did not start the sequencer");

    // out of range leaves all other fields at zero
    a_oor_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out_of_range) |->
            (o_kind_out == KIND_FREE && o_neighbour_count == '0 && !o_became_wall))
        else $error("out-of-range result carries data");

    // a new wall reports wall kind and a count at or above the cutoff
    a_wall_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_became_wall) |->
            (o_kind_out == KIND_WALL && o_neighbour_count >= r_cutoff && !o_out_of_range))
        else $error("wall marking inconsistent with count");

    // cross mode never exceeds its eight neighbours
    a_cross_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !r_mode) |-> (o_neighbour_count <= COUNT_W'(CROSS_STEPS)))
        else $error("cross count above eight");
`endif

endmodule

FILE: hw/rtl/gcw_ram.sv
// ----------------------------------------------------------------------------
// gcw_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gcw_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/gcw_nbr_unit.sv
// ----------------------------------------------------------------------------
// gcw_nbr_unit: shared coordinate unit
// Adds an offset to the centre cell, checks the result against the grid in
// use and forms the linear store address.
// ----------------------------------------------------------------------------
module gcw_nbr_unit #(
    parameter int MAX_SIDE = 64
) (
    input  logic [$clog2(MAX_SIDE)-1:0]             i_col,
    input  logic [$clog2(MAX_SIDE)-1:0]             i_row,
    input  gcw_pkg::t_offset                        i_offset,
    input  logic [$clog2(MAX_SIDE+1)-1:0]           i_eff_width,
    input  logic [$clog2(MAX_SIDE+1)-1:0]           i_eff_height,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]    o_addr,
    output logic                                    o_inside
);
    import gcw_pkg::*;

    localparam int COORD_W = $clog2(MAX_SIDE);
    localparam int ADDR_W  = $clog2(MAX_SIDE*MAX_SIDE);
    localparam logic [ADDR_W-1:0] SIDE_A = ADDR_W'(MAX_SIDE);

    logic signed [COORD_W+1:0] nc;
    logic signed [COORD_W+1:0] nr;
    logic                      col_ok;
    logic                      row_ok;
    logic [ADDR_W-1:0]         row_base;

    assign nc = $signed({2'b00, i_col}) + (COORD_W+2)'(i_offset.dc);
    assign nr = $signed({2'b00, i_row}) + (COORD_W+2)'(i_offset.dr);

    assign col_ok = !nc[COORD_W+1] && (nc[COORD_W:0] < (COORD_W+1)'(i_eff_width));
    assign row_ok = !nr[COORD_W+1] && (nr[COORD_W:0] < (COORD_W+1)'(i_eff_height));
    assign o_inside = col_ok && row_ok;

    assign row_base = ADDR_W'(nr[COORD_W-1:0]) * SIDE_A;
    // out-of-grid neighbours point at entry zero; their data is ignored
    assign o_addr = o_inside ? (row_base + ADDR_W'(nc[COORD_W-1:0])) : '0;

endmodule
